// ----- sv/csd_pkg.sv -----
// csd_pkg: shared types and constants of the compression spring-damper block
// depends on nothing; used by csd_iter, the top level, csd_checker and the testbench
package csd_pkg;

    // fixed point format and derived widths
    localparam int FRAC_BITS  = 16;
    localparam int DT_BITS    = 24;
    localparam int SH_BITS    = DT_BITS - FRAC_BITS;
    localparam int CAP_BITS   = 40;
    localparam int DIV_BITS   = CAP_BITS + 1;
    localparam int REM_BITS   = 35;
    localparam int CNT_BITS   = 6;
    localparam int NUM_BITS   = 64 + SH_BITS;

    localparam logic [31:0]         ONE_FX    = 32'(64'd1 << FRAC_BITS);
    localparam logic [DIV_BITS-1:0] FORCE_CAP = DIV_BITS'(64'd1 << CAP_BITS);

    // configuration register indexes
    localparam logic [1:0] CFG_STIFFNESS = 2'd0;
    localparam logic [1:0] CFG_DAMPING   = 2'd1;
    localparam logic [1:0] CFG_REST      = 2'd2;
    localparam logic [1:0] CFG_FREE_END  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DT   = 2'd1;
    localparam logic [1:0] ST_COLLAPSE = 2'd2;

    // shared divide / square root unit
    typedef enum logic
    {
        OP_DIV,
        OP_SQRT
    } iter_op_t;

    typedef struct packed
    {
        iter_op_t              op;
        logic [REM_BITS-1:0]   rem;
        logic [63:0]           bits;
        logic [REM_BITS-1:0]   divisor;
        logic [CNT_BITS-1:0]   count;
    } iter_cmd_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } iter_stat_t;

    // sequencer states
    typedef enum logic [4:0]
    {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_LEN,
        S_K_MUL,
        S_K_TAKE,
        S_D_MUL,
        S_D_TAKE,
        S_D_WAIT,
        S_TOTAL,
        S_J_MUL,
        S_J_TAKE,
        S_I_MUL,
        S_I_TAKE,
        S_I_WAIT,
        S_OUT
    } state_t;

endpackage

// ----- sv/csd_mul.sv -----
// csd_mul: shared 32x32 unsigned multiplier with registered product
// depends on nothing
module csd_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    // product is registered and ready in the cycle after the operands
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

// ----- sv/csd_iter.sv -----
// csd_iter: shared restoring divider and square root unit, one bit per cycle
// depends on csd_pkg
module csd_iter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  csd_pkg::iter_cmd_t            cmd,
    output csd_pkg::iter_stat_t           stat,
    output logic [csd_pkg::DIV_BITS-1:0]  quo
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [csd_pkg::CNT_BITS-1:0]    count_reg;
    csd_pkg::iter_op_t               op_reg;
    logic [csd_pkg::REM_BITS-1:0]    rem_reg;
    logic [csd_pkg::REM_BITS-1:0]    dvs_reg;
    logic [63:0]                     shift_reg;
    logic [csd_pkg::DIV_BITS-1:0]    quo_reg;

    logic [csd_pkg::REM_BITS-1:0]    cand;
    logic [csd_pkg::REM_BITS-1:0]    sub;
    logic                            ge;

    // shared compare and subtract
    always_comb
    begin
        if (op_reg == csd_pkg::OP_SQRT)
        begin
            cand = {rem_reg[32:0], shift_reg[63:62]};
            sub  = {1'b0, quo_reg[31:0], 2'b01};
        end
        else
        begin
            cand = {rem_reg[33:0], shift_reg[63]};
            sub  = dvs_reg;
        end
        ge = (cand >= sub);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= cmd.count;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == csd_pkg::CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg    <= cmd.op;
            rem_reg   <= cmd.rem;
            dvs_reg   <= cmd.divisor;
            shift_reg <= cmd.bits;
            quo_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (cand - sub) : cand;
            quo_reg <= {quo_reg[csd_pkg::DIV_BITS-2:0], ge};
            if (op_reg == csd_pkg::OP_SQRT)
                shift_reg <= {shift_reg[61:0], 2'b00};
            else
                shift_reg <= {shift_reg[62:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> count_reg != '0)
        else $error("busy with zero count");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && op_reg == csd_pkg::OP_DIV |-> rem_reg < dvs_reg)
        else $error("remainder not below divisor");

endmodule

// ----- sv/compression_spring_damper_impulse_top.sv -----
// compression spring-damper impulse block: each item is worked through the
// shared divide/square root unit (32 root steps, 41 steps for the
// damping quotient, 32 steps for each impulse component) and the shared
// multiplier; a zero time step goes straight to the output. One item at a time:
// the next item is taken once the current one is finished. rst_n clears the
// sequencer and loads the register reset values; no clearing pass is needed.
module compression_spring_damper_impulse_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] anchor_a_x,
    input  logic signed [31:0] anchor_a_y,
    input  logic signed [31:0] anchor_a_z,
    input  logic signed [31:0] anchor_b_x,
    input  logic signed [31:0] anchor_b_y,
    input  logic signed [31:0] anchor_b_z,
    input  logic [23:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] impulse_x,
    output logic signed [31:0] impulse_y,
    output logic signed [31:0] impulse_z,
    output logic [31:0]        spring_length,
    output logic signed [31:0] total_force,
    output logic [1:0]         status
);

    // configuration and spring state
    logic [31:0] stiffness_reg;
    logic [31:0] damping_reg;
    logic [31:0] rest_reg;
    logic        free_reg;
    logic [31:0] prev_reg;

    csd_pkg::state_t state_reg, state_next;

    // item working registers
    logic [31:0]        mag_reg [3];
    logic               sgn_reg [3];
    logic [23:0]        dt_reg;
    logic [1:0]         idx_reg;
    logic               half_reg;
    logic [65:0]        sum_reg;
    logic [32:0]        dist_reg;
    logic [31:0]        len_reg;
    logic [31:0]        dr_mag_reg;
    logic               dr_pos_reg;
    logic [31:0]        dl_mag_reg;
    logic               dl_pos_reg;
    logic [40:0]        fs_reg;
    logic [40:0]        fd_reg;
    logic signed [31:0] total_reg;
    logic [31:0]        j_reg;
    logic [31:0]        imp_reg [3];
    logic [1:0]         st_reg;

    // output register
    logic               out_valid_reg;
    logic [31:0]        ox_reg, oy_reg, oz_reg, olen_reg, oforce_reg;
    logic [1:0]         ost_reg;

    // shared units
    logic [31:0]                   mul_a, mul_b;
    logic [63:0]                   prod;
    logic                          it_start;
    csd_pkg::iter_cmd_t            it_cmd;
    csd_pkg::iter_stat_t           it_stat;
    logic [csd_pkg::DIV_BITS-1:0]  it_quo;

    csd_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    csd_iter u_iter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (it_start),
        .cmd   (it_cmd),
        .stat  (it_stat),
        .quo   (it_quo)
    );

    // input component arrays
    logic signed [31:0] a_in [3];
    logic signed [31:0] b_in [3];
    assign a_in[0] = anchor_a_x;
    assign a_in[1] = anchor_a_y;
    assign a_in[2] = anchor_a_z;
    assign b_in[0] = anchor_b_x;
    assign b_in[1] = anchor_b_y;
    assign b_in[2] = anchor_b_z;

    logic                  in_xfer;
    logic                  out_load;
    logic [65:0]           sum_add;
    logic [csd_pkg::NUM_BITS-1:0] dnum;
    logic [csd_pkg::NUM_BITS-1:0] dhi;
    logic                  dcap;
    logic                  icap;
    logic [32:0]           dist_c;
    logic [31:0]           len_c;
    logic [32:0]           dr_c, dl_c;
    logic [31:0]           total_mag;
    logic [32:0]           total_ext;
    logic [32:0]           im_c;
    logic                  neg_c;

    assign in_stall  = (state_reg != csd_pkg::S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_load  = (state_reg == csd_pkg::S_OUT) && (!out_valid_reg || !out_stall);

    // impulse sign and saturation
    function automatic logic [31:0] imp_val(input logic [32:0] im, input logic neg);
        logic [32:0] v;
        begin
            v = neg ? (33'd0 - im) : im;
            if (!neg && im[31])
                imp_val = 32'h7FFF_FFFF;
            else
                imp_val = v[31:0];
        end
    endfunction

    // shared arithmetic helpers
    always_comb
    begin
        sum_add   = sum_reg + 66'(prod);
        dnum      = csd_pkg::NUM_BITS'(prod) << csd_pkg::SH_BITS;
        dhi       = dnum >> csd_pkg::DIV_BITS;
        dcap      = dhi >= csd_pkg::NUM_BITS'(dt_reg);
        icap      = {1'b0, prod[63:32]} >= dist_reg;
        dist_c    = half_reg ? {it_quo[31:0], 1'b0} : {1'b0, it_quo[31:0]};
        if (free_reg || dist_reg < {1'b0, rest_reg})
            len_c = dist_reg[32] ? 32'hFFFF_FFFF : dist_reg[31:0];
        else
            len_c = rest_reg;
        dr_c      = {1'b0, len_c} - {1'b0, rest_reg};
        dl_c      = {1'b0, len_c} - {1'b0, prev_reg};
        total_ext = {total_reg[31], total_reg};
        total_mag = total_reg[31] ? 32'(33'd0 - total_ext) : total_reg;
        im_c      = (it_quo > csd_pkg::DIV_BITS'(33'h1_0000_0000 >> 1))
                  ? 33'h0_8000_0000 : it_quo[32:0];
        neg_c     = (!sgn_reg[idx_reg] && mag_reg[idx_reg] != 32'd0
                     && !total_reg[31] && total_reg != 32'sd0)
                  || (sgn_reg[idx_reg] && total_reg[31]);
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= csd_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and shared unit control
    always_comb
    begin
        state_next     = state_reg;
        it_start       = 1'b0;
        it_cmd.op      = csd_pkg::OP_DIV;
        it_cmd.rem     = '0;
        it_cmd.bits    = '0;
        it_cmd.divisor = '0;
        it_cmd.count   = '0;
        mul_a          = '0;
        mul_b          = '0;
        case (state_reg)
            csd_pkg::S_IDLE:
            begin
                if (in_xfer)
                    state_next = (time_step == 24'd0) ? csd_pkg::S_OUT : csd_pkg::S_SQ_MUL;
            end
            csd_pkg::S_SQ_MUL:
            begin
                mul_a      = half_reg ? (mag_reg[idx_reg] >> 1) : mag_reg[idx_reg];
                mul_b      = mul_a;
                state_next = csd_pkg::S_SQ_ACC;
            end
            csd_pkg::S_SQ_ACC:
            begin
                if (idx_reg != 2'd2)
                    state_next = csd_pkg::S_SQ_MUL;
                else if (sum_add[65:64] != 2'b00 && !half_reg)
                    state_next = csd_pkg::S_SQ_MUL;
                else
                    state_next = csd_pkg::S_SQRT_GO;
            end
            csd_pkg::S_SQRT_GO:
            begin
                it_start     = 1'b1;
                it_cmd.op    = csd_pkg::OP_SQRT;
                it_cmd.bits  = sum_reg[63:0];
                it_cmd.count = csd_pkg::CNT_BITS'(32);
                state_next   = csd_pkg::S_SQRT_WAIT;
            end
            csd_pkg::S_SQRT_WAIT:
            begin
                if (it_stat.done)
                    state_next = csd_pkg::S_LEN;
            end
            csd_pkg::S_LEN:
            begin
                state_next = csd_pkg::S_K_MUL;
            end
            csd_pkg::S_K_MUL:
            begin
                mul_a      = stiffness_reg;
                mul_b      = dr_mag_reg;
                state_next = csd_pkg::S_K_TAKE;
            end
            csd_pkg::S_K_TAKE:
            begin
                state_next = csd_pkg::S_D_MUL;
            end
            csd_pkg::S_D_MUL:
            begin
                mul_a      = damping_reg;
                mul_b      = dl_mag_reg;
                state_next = csd_pkg::S_D_TAKE;
            end
            csd_pkg::S_D_TAKE:
            begin
                if (dcap)
                    state_next = csd_pkg::S_TOTAL;
                else
                begin
                    it_start       = 1'b1;
                    it_cmd.op      = csd_pkg::OP_DIV;
                    it_cmd.rem     = csd_pkg::REM_BITS'(dhi);
                    it_cmd.bits    = {dnum[csd_pkg::DIV_BITS-1:0],
                                      (64 - csd_pkg::DIV_BITS)'(0)};
                    it_cmd.divisor = csd_pkg::REM_BITS'(dt_reg);
                    it_cmd.count   = csd_pkg::CNT_BITS'(csd_pkg::DIV_BITS);
                    state_next     = csd_pkg::S_D_WAIT;
                end
            end
            csd_pkg::S_D_WAIT:
            begin
                if (it_stat.done)
                    state_next = csd_pkg::S_TOTAL;
            end
            csd_pkg::S_TOTAL:
            begin
                if (len_reg == 32'd0 || dist_reg == 33'd0)
                    state_next = csd_pkg::S_OUT;
                else
                    state_next = csd_pkg::S_J_MUL;
            end
            csd_pkg::S_J_MUL:
            begin
                mul_a      = total_mag;
                mul_b      = {8'd0, dt_reg};
                state_next = csd_pkg::S_J_TAKE;
            end
            csd_pkg::S_J_TAKE:
            begin
                state_next = csd_pkg::S_I_MUL;
            end
            csd_pkg::S_I_MUL:
            begin
                mul_a      = mag_reg[idx_reg];
                mul_b      = j_reg;
                state_next = csd_pkg::S_I_TAKE;
            end
            csd_pkg::S_I_TAKE:
            begin
                if (icap)
                    state_next = (idx_reg == 2'd2) ? csd_pkg::S_OUT : csd_pkg::S_I_MUL;
                else
                begin
                    it_start       = 1'b1;
                    it_cmd.op      = csd_pkg::OP_DIV;
                    it_cmd.rem     = csd_pkg::REM_BITS'(prod[63:32]);
                    it_cmd.bits    = {prod[31:0], 32'd0};
                    it_cmd.divisor = csd_pkg::REM_BITS'(dist_reg);
                    it_cmd.count   = csd_pkg::CNT_BITS'(32);
                    state_next     = csd_pkg::S_I_WAIT;
                end
            end
            csd_pkg::S_I_WAIT:
            begin
                if (it_stat.done)
                    state_next = (idx_reg == 2'd2) ? csd_pkg::S_OUT : csd_pkg::S_I_MUL;
            end
            csd_pkg::S_OUT:
            begin
                if (out_load)
                    state_next = csd_pkg::S_IDLE;
            end
            default:
            begin
                state_next = csd_pkg::S_IDLE;
            end
        endcase
    end

    // configuration registers and previous length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= csd_pkg::ONE_FX;
            damping_reg   <= 32'd0;
            rest_reg      <= csd_pkg::ONE_FX;
            free_reg      <= 1'b0;
            prev_reg      <= csd_pkg::ONE_FX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csd_pkg::CFG_STIFFNESS: stiffness_reg <= cfg_wdata;
                csd_pkg::CFG_DAMPING:   damping_reg   <= cfg_wdata;
                csd_pkg::CFG_REST:
                begin
                    rest_reg <= cfg_wdata;
                    prev_reg <= cfg_wdata;
                end
                csd_pkg::CFG_FREE_END:  free_reg      <= cfg_wdata[0];
                default:                free_reg      <= free_reg;
            endcase
        end
        else if (state_reg == csd_pkg::S_LEN)
        begin
            prev_reg <= len_c;
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            csd_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        logic [32:0] diff;
                        diff       = {b_in[i][31], b_in[i]} - {a_in[i][31], a_in[i]};
                        sgn_reg[i] <= diff[32];
                        mag_reg[i] <= diff[32] ? 32'(33'd0 - diff) : diff[31:0];
                        imp_reg[i] <= 32'd0;
                    end
                    dt_reg    <= time_step;
                    idx_reg   <= 2'd0;
                    half_reg  <= 1'b0;
                    sum_reg   <= '0;
                    len_reg   <= 32'd0;
                    total_reg <= 32'sd0;
                    st_reg    <= (time_step == 24'd0) ? csd_pkg::ST_BAD_DT : csd_pkg::ST_OK;
                end
            end
            csd_pkg::S_SQ_ACC:
            begin
                if (idx_reg != 2'd2)
                begin
                    sum_reg <= sum_add;
                    idx_reg <= idx_reg + 2'd1;
                end
                else if (sum_add[65:64] != 2'b00 && !half_reg)
                begin
                    sum_reg  <= '0;
                    idx_reg  <= 2'd0;
                    half_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_add;
                end
            end
            csd_pkg::S_SQRT_WAIT:
            begin
                if (it_stat.done)
                    dist_reg <= dist_c;
            end
            csd_pkg::S_LEN:
            begin
                len_reg    <= len_c;
                dr_pos_reg <= !dr_c[32] && dr_c != 33'd0;
                dr_mag_reg <= dr_c[32] ? 32'(33'd0 - dr_c) : dr_c[31:0];
                dl_pos_reg <= !dl_c[32] && dl_c != 33'd0;
                dl_mag_reg <= dl_c[32] ? 32'(33'd0 - dl_c) : dl_c[31:0];
            end
            csd_pkg::S_K_TAKE:
            begin
                if ((prod >> csd_pkg::FRAC_BITS) > 64'(csd_pkg::FORCE_CAP))
                    fs_reg <= csd_pkg::FORCE_CAP;
                else
                    fs_reg <= 41'(prod >> csd_pkg::FRAC_BITS);
            end
            csd_pkg::S_D_TAKE:
            begin
                if (dcap)
                    fd_reg <= csd_pkg::FORCE_CAP;
            end
            csd_pkg::S_D_WAIT:
            begin
                if (it_stat.done)
                    fd_reg <= (it_quo > csd_pkg::FORCE_CAP) ? csd_pkg::FORCE_CAP : it_quo;
            end
            csd_pkg::S_TOTAL:
            begin
                logic signed [42:0] fsum;
                fsum = (dr_pos_reg ? -$signed({2'b00, fs_reg}) : $signed({2'b00, fs_reg}))
                     + (dl_pos_reg ? -$signed({2'b00, fd_reg}) : $signed({2'b00, fd_reg}));
                if (fsum > 43'sd2147483647)
                    total_reg <= 32'sh7FFF_FFFF;
                else if (fsum < -43'sd2147483648)
                    total_reg <= 32'sh8000_0000;
                else
                    total_reg <= fsum[31:0];
                if (len_reg == 32'd0 || dist_reg == 33'd0)
                    st_reg <= csd_pkg::ST_COLLAPSE;
                else
                    st_reg <= csd_pkg::ST_OK;
                idx_reg <= 2'd0;
            end
            csd_pkg::S_J_TAKE:
            begin
                j_reg <= prod[55:24];
            end
            csd_pkg::S_I_TAKE:
            begin
                if (icap)
                begin
                    imp_reg[idx_reg] <= imp_val(33'h0_8000_0000, neg_c);
                    idx_reg          <= idx_reg + 2'd1;
                end
            end
            csd_pkg::S_I_WAIT:
            begin
                if (it_stat.done)
                begin
                    imp_reg[idx_reg] <= imp_val(im_c, neg_c);
                    idx_reg          <= idx_reg + 2'd1;
                end
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ox_reg     <= imp_reg[0];
            oy_reg     <= imp_reg[1];
            oz_reg     <= imp_reg[2];
            olen_reg   <= len_reg;
            oforce_reg <= total_reg;
            ost_reg    <= st_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign impulse_x     = ox_reg;
    assign impulse_y     = oy_reg;
    assign impulse_z     = oz_reg;
    assign spring_length = olen_reg;
    assign total_force   = oforce_reg;
    assign status        = ost_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        it_start |-> !it_stat.busy)
        else $error("shared unit started while busy");

    a_bad_dt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ost_reg == csd_pkg::ST_BAD_DT |->
            olen_reg == 32'd0 && oforce_reg == 32'd0 && ox_reg == 32'd0)
        else $error("bad time step result not cleared");

    a_collapse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ost_reg == csd_pkg::ST_COLLAPSE |->
            ox_reg == 32'd0 && oy_reg == 32'd0 && oz_reg == 32'd0)
        else $error("collapsed spring with impulse");

endmodule

// ----- bench/csd_checker.sv -----
// csd_checker: watches both channels of the spring-damper block, predicts
// each result and compares it; depends on csd_pkg
`timescale 1ns / 100ps

module csd_checker
    import csd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] anchor_a_x,
    input  logic signed [31:0] anchor_a_y,
    input  logic signed [31:0] anchor_a_z,
    input  logic signed [31:0] anchor_b_x,
    input  logic signed [31:0] anchor_b_y,
    input  logic signed [31:0] anchor_b_z,
    input  logic [23:0]        time_step,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] impulse_x,
    input  logic signed [31:0] impulse_y,
    input  logic signed [31:0] impulse_z,
    input  logic [31:0]        spring_length,
    input  logic signed [31:0] total_force,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);

    typedef struct packed
    {
        logic signed [31:0] ix;
        logic signed [31:0] iy;
        logic signed [31:0] iz;
        logic [31:0]        len;
        logic signed [31:0] force_total;
        logic [1:0]         st;
    } impulse_t;

    localparam logic [63:0] CAP = 64'd1 << CAP_BITS;

    // mirror of the block's registers and stored length
    logic [31:0] k_coef, d_coef, rest, prev_len;
    logic        free_end;
    impulse_t    expected_q[$];

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] absl(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // compute the anchor-one impulse for one transfer, updating stored length
    function automatic impulse_t predict_impulse(input logic signed [31:0] a[3],
                                                 input logic signed [31:0] b[3],
                                                 input logic [23:0] dt);
        impulse_t    res;
        longint      dv[3];
        logic [63:0] m[3], s0, s1, s2, sum, sum2, span, len64, fs, p, q, r, fd, j, im;
        logic        over, neg;
        logic [31:0] len;
        longint      dr, dl, total, v;
        res = '0;
        if (dt == 0)
        begin
            res.st = ST_BAD_DT;
            return res;
        end
        for (int i = 0; i < 3; i++)
        begin
            dv[i] = longint'(b[i]) - longint'(a[i]);
            m[i] = absl(dv[i]);
        end
        s0 = m[0] * m[0];
        s1 = m[1] * m[1];
        s2 = m[2] * m[2];
        sum = s0 + s1;
        over = sum < s0;
        sum2 = sum + s2;
        if (sum2 < sum) over = 1;
        if (over)
            span = root64((m[0] >> 1) * (m[0] >> 1) + (m[1] >> 1) * (m[1] >> 1)
                          + (m[2] >> 1) * (m[2] >> 1)) << 1;
        else
            span = root64(sum2);
        len64 = rest;
        if (free_end || span < 64'(rest)) len64 = span;
        if (len64 > 64'hFFFF_FFFF) len64 = 64'hFFFF_FFFF;
        len = len64[31:0];
        dr = longint'(len) - longint'(rest);
        fs = (64'(k_coef) * absl(dr)) >> FRAC_BITS;
        if (fs > CAP) fs = CAP;
        dl = longint'(len) - longint'(prev_len);
        p = 64'(d_coef) * absl(dl);
        q = p / dt;
        r = p % dt;
        if (q > (CAP >> SH_BITS)) fd = CAP;
        else
        begin
            fd = (q << SH_BITS) + ((r << SH_BITS) / dt);
            if (fd > CAP) fd = CAP;
        end
        total = (dr > 0 ? -longint'(fs) : longint'(fs)) + (dl > 0 ? -longint'(fd) : longint'(fd));
        total = clip32(total);
        prev_len = len;
        res.len = len;
        res.force_total = total[31:0];
        if (len == 0 || span == 0)
        begin
            res.st = ST_COLLAPSE;
            return res;
        end
        j = (absl(total) * dt) >> DT_BITS;
        for (int i = 0; i < 3; i++)
        begin
            im = (m[i] * j) / span;
            if (im > (64'd1 << 31)) im = 64'd1 << 31;
            neg = (dv[i] > 0 && total > 0) || (dv[i] < 0 && total < 0);
            v = clip32(neg ? -longint'(im) : longint'(im));
            if (i == 0) res.ix = v[31:0];
            else if (i == 1) res.iy = v[31:0];
            else res.iz = v[31:0];
        end
        res.st = ST_OK;
        return res;
    endfunction

    assign pending = expected_q.size();

    // registers, input transfers and result transfers, all sampled at the edge
    always @(posedge clk or negedge rst_n)
    begin
        impulse_t got, exp_r;
        if (!rst_n)
        begin
            k_coef = ONE_FX;
            d_coef = 0;
            rest = ONE_FX;
            prev_len = ONE_FX;
            free_end = 0;
            expected_q.delete();
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STIFFNESS: k_coef = cfg_wdata;
                    CFG_DAMPING:   d_coef = cfg_wdata;
                    CFG_REST:
                    begin
                        rest = cfg_wdata;
                        prev_len = cfg_wdata;
                    end
                    CFG_FREE_END:  free_end = cfg_wdata[0];
                    default:       free_end = free_end;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = '{impulse_x, impulse_y, impulse_z, spring_length, total_force, status};
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", exp_r, got);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(predict_impulse(
                    '{anchor_a_x, anchor_a_y, anchor_a_z},
                    '{anchor_b_x, anchor_b_y, anchor_b_z}, time_step));
        end
    end

endmodule

// ----- bench/tb_compression_spring_damper_impulse_top.sv -----
// tb_compression_spring_damper_impulse_top: drives stimulus and register
// settings into the spring-damper block; depends on csd_pkg, csd_checker and the top level
`timescale 1ns / 100ps

module tb_compression_spring_damper_impulse_top;
    import csd_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] anchor_a_x, anchor_a_y, anchor_a_z;
    logic signed [31:0] anchor_b_x, anchor_b_y, anchor_b_z;
    logic [23:0]        time_step;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] impulse_x, impulse_y, impulse_z;
    logic [31:0]        spring_length;
    logic signed [31:0] total_force;
    logic [1:0]         status;
    int                 fail_count, pending, results_seen;
    logic               hold_off;
    int                 items_sent;

    compression_spring_damper_impulse_top uut (.*);

    csd_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 99);
        if (g < 45) return 0;
        if (g < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stall: random gaps, plus one long hold-off on request
    initial
    begin
        int g;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1;
                for (int i = 0; i < 1500; i++) @(posedge clk);
                out_stall <= 0;
            end
            else
            begin
                g = gap_len();
                if ($urandom_range(0, 3) == 0 && g > 0)
                begin
                    out_stall <= 1;
                    repeat (g) @(posedge clk);
                    out_stall <= 0;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // one anchor coordinate: extremes, small values or full range
    function automatic logic [31:0] coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [31:0] ax, ay, az, bx, by, bz,
                             input logic [23:0] dt);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        anchor_a_x <= ax;
        anchor_a_y <= ay;
        anchor_a_z <= az;
        anchor_b_x <= bx;
        anchor_b_y <= by;
        anchor_b_z <= bz;
        time_step <= dt;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_random();
        logic [23:0] dt;
        case ($urandom_range(0, 9))
            0: dt = 0;
            1: dt = 24'hFF_FFFF;
            2: dt = 1;
            default: dt = 24'($urandom_range(1, 24'hFF_FFFF));
        endcase
        send_item(coord(), coord(), coord(), coord(), coord(), coord(), dt);
    endtask

    // let the block drain before touching registers
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] kset[4], dset[4], rset[4];
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_STIFFNESS;
        cfg_wdata = 0;
        in_valid = 0;
        anchor_a_x = 0;
        anchor_a_y = 0;
        anchor_a_z = 0;
        anchor_b_x = 0;
        anchor_b_y = 0;
        anchor_b_z = 0;
        time_step = 0;
        hold_off = 0;
        items_sent = 0;
        kset = '{32'd1, ONE_FX, 32'hFFFF_FFFF, 32'h0004_0000};
        dset = '{32'd0, ONE_FX, 32'hFFFF_FFFF, 32'h0000_8000};
        rset = '{32'd1, ONE_FX, 32'hFFFF_FFFF, 32'h0003_0000};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset settings, zero step, collapse, far anchors, extremes
        send_item(0, 0, 0, 0, 0, 0, 24'd1000);
        send_item(0, 0, 0, 32'h0001_0000, 0, 0, 24'd0);
        send_item(0, 0, 0, 32'h0000_8000, 0, 0, 24'h10_0000);
        send_item(0, 0, 0, 32'h0000_8000, 32'h0000_4000, 0, 24'hFF_FFFF);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'd1);
        send_item(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0,
                  32'h7FFF_FFFF, 24'hFF_FFFF);
        drain();
        write_reg(CFG_FREE_END, 1);
        write_reg(CFG_DAMPING, 32'hFFFF_FFFF);
        write_reg(CFG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(CFG_REST, 32'hFFFF_FFFF);
        send_item(0, 0, 0, 0, 0, 0, 24'd5);
        send_item(0, 0, 0, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0010, 24'd1);
        send_item(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 24'hFF_FFFF);
        send_item(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
                  32'hF0F0_F0F0, 32'h5555_5555, 32'hAAAA_AAAA, 24'hAA_AAAA);
        send_item(1, 2, 3, 2, 4, 6, 24'h55_5555);
        drain();

        // random phases across register settings, one with a long receiver hold-off
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(CFG_STIFFNESS, ph < 4 ? kset[ph] : ($urandom_range(0, 1) ? kset[ph % 4] : $urandom));
            write_reg(CFG_DAMPING, ph < 4 ? dset[ph] : ($urandom_range(0, 1) ? dset[ph % 4] : $urandom));
            write_reg(CFG_REST, ph < 4 ? rset[ph] : ($urandom_range(0, 1) ? rset[ph % 4] : $urandom));
            write_reg(CFG_FREE_END, ph % 2);
            for (int n = 0; n < 36; n++)
            begin
                if (ph == 5 && n == 3)
                    hold_off <= 1;
                if (ph == 5 && n == 4)
                    hold_off <= 0;
                send_random();
            end
            drain();
        end

        $display("sent %0d items over 14 register settings, %0d results checked",
                 items_sent, results_seen);
        $display("covered zero steps, collapsed springs, far anchors and saturation");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
